### rtl/core/two_stack_queue_core_assert.svh
// Assertion macros for the two-stack queue core.
// Used by the top level only; no other dependencies.
`ifndef TWO_STACK_QUEUE_CORE_ASSERT_SVH
`define TWO_STACK_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tsq_pkg.sv
// Shared types and constants for the two-stack queue core.
// No dependencies.
package tsq_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [DATA_W-1:0] EMPTY_DATA = '1;   // -1
    localparam logic [DATA_W-1:0] ENQ_DATA   = '0;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_XFER
    } back_state_t;

endpackage

### rtl/core/tsq_front.sv
// Front end: accepts input transactions, classifies them into commands
// and holds them in a two-entry command queue. Depends on tsq_pkg.
module tsq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic signed [tsq_pkg::DATA_W-1:0] value,
    output logic                          cmd_valid,
    output tsq_pkg::cmd_t                 cmd,
    input  logic                          cmd_pop
);
    import tsq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       new_cmd;

    // Classify the incoming transaction
    always_comb
    begin
        new_cmd.kind  = op ? CMD_DEQ : CMD_ENQ;
        new_cmd.value = value;
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

### rtl/core/tsq_back.sv
// Back end: executes commands against the input and output stacks and
// drives the result register. Depends on tsq_pkg.
module tsq_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  tsq_pkg::cmd_t                     cmd,
    output logic                              cmd_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [tsq_pkg::DATA_W-1:0] data_out,
    output logic [1:0]                        status
);
    import tsq_pkg::*;

    logic [DATA_W-1:0] in_mem  [STACK_DEPTH];
    logic [DATA_W-1:0] out_mem [STACK_DEPTH];
    logic [DATA_W-1:0] in_rd_data;
    logic [DATA_W-1:0] out_rd_data;

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  in_count_reg, in_count_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic [CNT_W-1:0]  in_top, out_top;

    logic              in_we, in_re, out_we, out_re;
    logic [ADDR_W-1:0] in_waddr, in_raddr, out_waddr, out_raddr;

    logic              res_valid_reg, res_valid_next;
    logic [DATA_W-1:0] res_data_reg;
    status_t           res_stat_reg;
    logic              res_load;
    logic [DATA_W-1:0] res_data;
    status_t           res_stat;
    logic              out_free;

    assign in_top   = in_count_reg - CNT_W'(1);
    assign out_top  = out_count_reg - CNT_W'(1);
    assign out_free = !res_valid_reg || out_ready;

    // Sequencer: next state, stack counts, memory strobes, result load
    always_comb
    begin
        state_next     = state_reg;
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        cmd_pop        = 1'b0;
        in_we          = 1'b0;
        in_re          = 1'b0;
        out_we         = 1'b0;
        out_re         = 1'b0;
        in_waddr       = in_count_reg[ADDR_W-1:0];
        in_raddr       = in_top[ADDR_W-1:0];
        out_waddr      = out_count_reg[ADDR_W-1:0];
        out_raddr      = out_top[ADDR_W-1:0];
        res_load       = 1'b0;
        res_data       = ENQ_DATA;
        res_stat       = STAT_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_ENQ:
                        begin
                            res_load = 1'b1;
                            if (in_count_reg == CNT_W'(STACK_DEPTH))
                            begin
                                res_stat = STAT_FULL;
                            end
                            else
                            begin
                                in_we         = 1'b1;
                                in_count_next = in_count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (in_count_reg == '0 && out_count_reg == '0)
                            begin
                                res_load = 1'b1;
                                res_data = EMPTY_DATA;
                                res_stat = STAT_EMPTY;
                            end
                            else if (out_count_reg != '0)
                            begin
                                out_re         = 1'b1;
                                out_count_next = out_top;
                                state_next     = S_POP;
                            end
                            else
                            begin
                                // output stack empty: start moving the input stack
                                in_re         = 1'b1;
                                in_count_next = in_top;
                                state_next    = S_XFER;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_load   = 1'b1;
                res_data   = out_rd_data;
                state_next = S_IDLE;
            end
            S_XFER:
            begin
                if (in_count_reg != '0)
                begin
                    // write the element read last cycle, read the next one
                    out_we         = 1'b1;
                    out_count_next = out_count_reg + CNT_W'(1);
                    in_re          = 1'b1;
                    in_count_next  = in_top;
                end
                else
                begin
                    // oldest element is popped straight away, never stored
                    res_load   = 1'b1;
                    res_data   = in_rd_data;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register handshake
    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= res_data;
            res_stat_reg <= res_stat;
        end
    end

    // Input stack memory
    always_ff @(posedge clk)
    begin
        if (in_we)
        begin
            in_mem[in_waddr] <= cmd.value;
        end
        if (in_re)
        begin
            in_rd_data <= in_mem[in_raddr];
        end
    end

    // Output stack memory
    always_ff @(posedge clk)
    begin
        if (out_we)
        begin
            out_mem[out_waddr] <= in_rd_data;
        end
        if (out_re)
        begin
            out_rd_data <= out_mem[out_raddr];
        end
    end

    assign out_valid = res_valid_reg;
    assign data_out  = res_data_reg;
    assign status    = res_stat_reg;

endmodule

### rtl/core/two_stack_queue_core.sv
// Enqueue and empty dequeue: a command passes the front queue slot and then the
// result register; a dequeue from a loaded output stack also passes the registered
// stack memory read. A dequeue that finds the output stack empty moves the input
// stack, one element a cycle: the oldest element becomes the result, the rest go to
// the output stack. The back end takes no command while a stack is read or a result waits.
// Reset (rst_n, async, active low) empties both stacks and the command queue.
`include "two_stack_queue_core_assert.svh"
module two_stack_queue_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic signed [tsq_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [tsq_pkg::DATA_W-1:0] data_out,
    output logic [1:0]                        status
);
    import tsq_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    tsq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tsq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .status    (status)
    );

    // Checks
    `TSQ_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd_pop, cmd_valid, "command popped from empty queue")
    `TSQ_ASSERT_IMP(a_room_when_empty, clk, rst_n, !cmd_valid, in_ready, "empty queue refuses input")
    `TSQ_ASSERT_IMP(a_empty_data, clk, rst_n, out_valid && status == STAT_EMPTY, data_out == EMPTY_DATA, "empty result without -1")
    `TSQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(data_out) && $stable(status), "result changed while waiting")

endmodule
